### src/mns_pkg.sv
// Shared constants, types and helpers for the melody note sequencer
package mns_pkg;

   // table and group sizing
   localparam int TABLE_DEPTH   = 256;
   localparam int MAX_GROUP     = 8;
   localparam int DURATION_BITS = 16;

   // derived widths
   localparam int ADDR_BITS  = $clog2(TABLE_DEPTH);
   localparam int PTR_BITS   = ADDR_BITS + 1;
   localparam int LEN_BITS   = 9;
   localparam int WAIT_BITS  = DURATION_BITS + 1;
   localparam int CNT_BITS   = $clog2(MAX_GROUP + 1);
   localparam int IDX_BITS   = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int POS_BITS   = 8;
   localparam int POS_SCALE  = 255;
   localparam int DIVD_BITS  = PTR_BITS + POS_BITS;
   localparam int DSTEP_BITS = $clog2(DIVD_BITS + 1);

   // request function codes
   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_START = 2'd1,
      FUNC_STOP  = 2'd2,
      FUNC_TICK  = 2'd3
   } func_type;

   typedef logic [PTR_BITS-1:0]  ptr_type;
   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [WAIT_BITS-1:0] wait_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;
   typedef logic [DIVD_BITS-1:0] divd_type;

   // one stored table entry
   typedef struct packed {
      logic [2:0]               chan;
      logic [6:0]               note;
      logic [DURATION_BITS-1:0] dur;
   } entry_type;

   // one note waiting to be sent
   typedef struct packed {
      logic [2:0] chan;
      logic [6:0] note;
   } voice_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_NOTE,
      ST_DIV,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic mem_write;
      logic ptr_clear;
      logic ptr_inc;
      logic run_set;
      logic run_clear;
      logic wait_clear;
      logic wait_dec;
      logic wait_load_dur;
      logic wait_one;
      logic cnt_clear;
      logic note_store;
      logic div_start;
      logic emit_clear;
      logic emit_next;
   } ctrl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      func_type func;
      logic     running;
      logic     wait_gt1;
      logic     ptr_lt_len;
      logic     len_zero;
      logic     dur_nonzero;
      logic     group_end;
      logic     div_done;
      logic     last_result;
   } dp_status_type;

   // melody length clamped to the table depth
   function automatic ptr_type eff_length(input logic [LEN_BITS-1:0] len);
      if (int'(len) > TABLE_DEPTH) begin
         return ptr_type'(TABLE_DEPTH);
      end
      return ptr_type'(len);
   endfunction

endpackage

### src/mns_divider.sv
// Restoring divider, one quotient bit per cycle, for the position figure
module mns_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  mns_pkg::divd_type dividend,
   input  mns_pkg::ptr_type divisor,
   output logic             done,
   output mns_pkg::divd_type quotient
);
   import mns_pkg::*;

   divd_type                quo_ff, quo_in;
   ptr_type                 rem_ff, rem_in;
   ptr_type                 div_ff, div_in;
   logic [DSTEP_BITS-1:0]   step_ff, step_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [PTR_BITS:0]       trial;
   logic [PTR_BITS:0]       diff;
   logic                    fits;

   // one shift and subtract step
   always_comb begin
      trial = {rem_ff, quo_ff[DIVD_BITS-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = trial >= {1'b0, div_ff};
   end

   // iteration control
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         step_in = DSTEP_BITS'(DIVD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVD_BITS-2:0], fits};
         rem_in  = fits ? diff[PTR_BITS-1:0] : trial[PTR_BITS-1:0];
         step_in = step_ff - DSTEP_BITS'(1);
         if (step_ff == DSTEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // operand registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### src/mns_datapath.sv
// Note table, play pointer, wait counter, note buffer and position logic
module mns_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  mns_pkg::ctrl_cmd_type        cmd,
   output mns_pkg::dp_status_type       status,
   input  logic [1:0]                   req_func,
   input  logic [7:0]                   req_entry_index,
   input  logic [2:0]                   req_entry_channel,
   input  logic [6:0]                   req_entry_note,
   input  logic [15:0]                  req_entry_duration,
   input  logic                         csr_write,
   input  logic [mns_pkg::LEN_BITS-1:0] csr_song_length,
   output logic                         rsp_note_on,
   output logic [2:0]                   rsp_out_channel,
   output logic [6:0]                   rsp_out_note,
   output logic                         rsp_last,
   output logic [7:0]                   rsp_position,
   output logic                         rsp_playing
);
   import mns_pkg::*;

   // captured request
   func_type                 func_ff;
   addr_type                 index_ff;
   entry_type                entry_ff;

   // configuration and play state
   logic [LEN_BITS-1:0]      length_ff;
   ptr_type                  ptr_ff, ptr_in;
   wait_type                 wait_ff, wait_in;
   logic                     running_ff, running_in;
   cnt_type                  count_ff, count_in;
   cnt_type                  emit_ff, emit_in;
   logic [POS_BITS-1:0]      position_ff;

   // storage
   entry_type                note_table_ff [TABLE_DEPTH];
   entry_type                rd_data_ff;
   voice_type                note_buf_ff [MAX_GROUP];

   ptr_type                  len_eff;
   ptr_type                  ptr_next;
   divd_type                 dividend;
   divd_type                 quotient;
   logic                     div_done;
   voice_type                voice;

   assign len_eff  = eff_length(length_ff);
   assign ptr_next = ptr_ff + PTR_BITS'(1);
   assign dividend = DIVD_BITS'(ptr_ff) * DIVD_BITS'(POS_SCALE);

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff       <= func_type'(req_func);
         index_ff      <= addr_type'(req_entry_index);
         entry_ff.chan <= req_entry_channel;
         entry_ff.note <= req_entry_note;
         entry_ff.dur  <= DURATION_BITS'(req_entry_duration);
      end
   end

   // melody length register
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (csr_write) begin
         length_ff <= csr_song_length;
      end
   end

   // note table, single write port and registered read at the pointer
   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         note_table_ff[index_ff] <= entry_ff;
      end
      rd_data_ff <= note_table_ff[ptr_ff[ADDR_BITS-1:0]];
   end

   // pointer, wait counter, running flag and counters
   always_comb begin
      ptr_in     = ptr_ff;
      wait_in    = wait_ff;
      running_in = running_ff;
      count_in   = count_ff;
      emit_in    = emit_ff;
      if (cmd.ptr_clear) begin
         ptr_in = '0;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_next;
      end
      if (cmd.wait_clear) begin
         wait_in = '0;
      end else if (cmd.wait_dec) begin
         wait_in = wait_ff - WAIT_BITS'(1);
      end else if (cmd.wait_load_dur) begin
         wait_in = WAIT_BITS'(rd_data_ff.dur) + WAIT_BITS'(1);
      end else if (cmd.wait_one) begin
         wait_in = WAIT_BITS'(1);
      end
      if (cmd.run_set) begin
         running_in = 1'b1;
      end else if (cmd.run_clear) begin
         running_in = 1'b0;
      end
      if (cmd.cnt_clear) begin
         count_in = '0;
      end else if (cmd.note_store) begin
         count_in = count_ff + CNT_BITS'(1);
      end
      if (cmd.emit_clear) begin
         emit_in = '0;
      end else if (cmd.emit_next) begin
         emit_in = emit_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         wait_ff    <= '0;
         running_ff <= 1'b0;
         count_ff   <= '0;
         emit_ff    <= '0;
      end else begin
         ptr_ff     <= ptr_in;
         wait_ff    <= wait_in;
         running_ff <= running_in;
         count_ff   <= count_in;
         emit_ff    <= emit_in;
      end
   end

   // group note buffer
   always_ff @(posedge clock) begin
      if (cmd.note_store) begin
         note_buf_ff[count_ff[IDX_BITS-1:0]] <= '{chan: rd_data_ff.chan,
                                                  note: rd_data_ff.note};
      end
   end

   // position divider
   mns_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (len_eff),
      .done     (div_done),
      .quotient (quotient)
   );

   // position with saturation, zero for an empty melody
   always_ff @(posedge clock) begin
      if (div_done) begin
         if (len_eff == '0) begin
            position_ff <= '0;
         end else if (quotient > DIVD_BITS'(POS_SCALE)) begin
            position_ff <= POS_BITS'(POS_SCALE);
         end else begin
            position_ff <= quotient[POS_BITS-1:0];
         end
      end
   end

   // status to the controller
   always_comb begin
      status.func        = func_ff;
      status.running     = running_ff;
      status.wait_gt1    = wait_ff > WAIT_BITS'(1);
      status.ptr_lt_len  = ptr_ff < len_eff;
      status.len_zero    = len_eff == '0;
      status.dur_nonzero = rd_data_ff.dur != '0;
      status.group_end   = !(ptr_next < len_eff) ||
                           (count_ff == CNT_BITS'(MAX_GROUP - 1));
      status.div_done    = div_done;
      status.last_result = (count_ff == '0) || (emit_ff + CNT_BITS'(1) == count_ff);
   end

   // response fields
   assign voice           = note_buf_ff[emit_ff[IDX_BITS-1:0]];
   assign rsp_note_on     = count_ff != '0;
   assign rsp_out_channel = (count_ff != '0) ? voice.chan : 3'd0;
   assign rsp_out_note    = (count_ff != '0) ? voice.note : 7'd0;
   assign rsp_last        = status.last_result;
   assign rsp_position    = position_ff;
   assign rsp_playing     = running_ff;

endmodule

### src/mns_ctrl.sv
// Sequencing state machine for the melody note sequencer
module mns_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mns_pkg::dp_status_type status,
   output mns_pkg::ctrl_cmd_type  cmd
);
   import mns_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DIV;
            case (status.func)
               FUNC_START: begin
                  if (!status.len_zero) begin
                     state_in = ST_READ;
                  end
               end
               FUNC_TICK: begin
                  if (status.running && !status.wait_gt1 && status.ptr_lt_len) begin
                     state_in = ST_READ;
                  end
               end
               default: state_in = ST_DIV;
            endcase
         end
         ST_READ: state_in = ST_NOTE;
         ST_NOTE: begin
            if (status.dur_nonzero || status.group_end) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DIV:      state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready && status.last_result) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            case (status.func)
               FUNC_LOAD: begin
                  cmd.mem_write = 1'b1;
                  cmd.cnt_clear = 1'b1;
               end
               FUNC_START: begin
                  cmd.ptr_clear = 1'b1;
                  cmd.cnt_clear = 1'b1;
                  if (status.len_zero) begin
                     cmd.run_clear  = 1'b1;
                     cmd.wait_clear = 1'b1;
                  end else begin
                     cmd.run_set = 1'b1;
                  end
               end
               FUNC_STOP: begin
                  cmd.ptr_clear  = 1'b1;
                  cmd.cnt_clear  = 1'b1;
                  cmd.run_clear  = 1'b1;
                  cmd.wait_clear = 1'b1;
               end
               FUNC_TICK: begin
                  cmd.cnt_clear = 1'b1;
                  if (status.running) begin
                     if (status.wait_gt1) begin
                        cmd.wait_dec = 1'b1;
                     end else begin
                        cmd.wait_clear = 1'b1;
                        if (!status.ptr_lt_len) begin
                           cmd.run_clear = 1'b1;
                        end
                     end
                  end
               end
               default: cmd = '0;
            endcase
         end
         ST_READ: cmd = '0;
         ST_NOTE: begin
            cmd.note_store = 1'b1;
            cmd.ptr_inc    = 1'b1;
            if (status.dur_nonzero) begin
               cmd.wait_load_dur = 1'b1;
            end else if (status.group_end) begin
               cmd.wait_one = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_start  = 1'b1;
            cmd.emit_clear = 1'b1;
         end
         ST_DIV_WAIT: cmd = '0;
         ST_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.emit_next = rsp_ready && !status.last_result;
         end
         default: cmd = '0;
      endcase
   end

endmodule

### src/melody_note_sequencer.sv
// Top level of the melody note sequencer
//
// Plays a table of 256 notes (channel, note, duration). Requests load an
// entry, start, stop, or deliver one timer tick; each request yields one or
// more responses, one per note played (up to 8 per group) or a single
// response with note_on low, all carrying the final position and playing
// flag. One request is handled at a time: it is accepted and decoded, each
// note of the group is read from the note table, then the position figure
// is worked out on the 17-step bit-serial divider, and each response is held
// until it is taken. The song length is written through the csr port; the
// user must write it only while no request is in progress, since the block
// itself does not enforce this.
module melody_note_sequencer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_func,
   input  logic [7:0]                   req_entry_index,
   input  logic [2:0]                   req_entry_channel,
   input  logic [6:0]                   req_entry_note,
   input  logic [15:0]                  req_entry_duration,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_note_on,
   output logic [2:0]                   rsp_out_channel,
   output logic [6:0]                   rsp_out_note,
   output logic                         rsp_last,
   output logic [7:0]                   rsp_position,
   output logic                         rsp_playing,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mns_pkg::LEN_BITS-1:0] csr_song_length
);
   import mns_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // length register is always writable
   assign csr_ready = 1'b1;

   // controller
   mns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   mns_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_func           (req_func),
      .req_entry_index    (req_entry_index),
      .req_entry_channel  (req_entry_channel),
      .req_entry_note     (req_entry_note),
      .req_entry_duration (req_entry_duration),
      .csr_write          (csr_valid && csr_ready),
      .csr_song_length    (csr_song_length),
      .rsp_note_on        (rsp_note_on),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_out_note       (rsp_out_note),
      .rsp_last           (rsp_last),
      .rsp_position       (rsp_position),
      .rsp_playing        (rsp_playing)
   );

endmodule
